[rtl/aabb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared widths, constants and helpers for the swept box collision block.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // Field widths of one word
  localparam int COORD_W = 32;
  localparam int HALF_W  = 31;
  localparam int IN_W    = 320;  // ten packed fields, 316 bits, padded to bytes
  localparam int OUT_W   = 72;   // hit, end_x, end_y, 65 bits, padded to bytes

  // Small-motion reciprocal 99999.9 written as a ratio of integers
  localparam int RECIP_NUM = 999999;
  localparam int RECIP_DEN = 10;

  // Motion threshold 0.00001 expressed as a divisor of 1.0
  localparam int TINY_DIV = 100000;

  // Saturate a 33-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/aabb_swept_collision_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_swept_collision_top
// Swept box-versus-box test in 2-D on signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One box pair is accepted every cycle while the output word is taken. The
// latency is set by the four slab divisions, which run as a restoring divider
// with one quotient bit per pipeline stage; the quotients are NW bits wide,
// NW = max(FRAC_BITS + 35, 55). The whole pipeline stalls as one while the
// output word is not taken; nothing is dropped or repeated.
module aabb_swept_collision_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // box_a_center_x, box_a_center_y, box_a_half_w, box_a_half_h,
  // box_b_center_x, box_b_center_y, box_b_half_w, box_b_half_h,
  // move_x, move_y (lowest bits first, zero padded)
  input  logic [aabb_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // hit, end_x, end_y (lowest bits first, zero padded)
  output logic [aabb_pkg::OUT_W-1:0]   m_tdata
);
  import aabb_pkg::*;

  localparam int NW  = (FRAC_BITS + 35 > 55) ? FRAC_BITS + 35 : 55;
  localparam int NSW = NW + 1;
  localparam int TW  = FRAC_BITS + 1;
  localparam int PW  = 33 + FRAC_BITS;
  localparam logic [31:0] TINY_MAX = 32'((64'd1 << FRAC_BITS) / 64'(TINY_DIV));
  localparam logic signed [NSW-1:0] ONE_T = {{(NSW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [PW-1:0] RND = ({{(PW-1){1'b0}}, 1'b1} << FRAC_BITS) - 1'b1;

  typedef struct packed {
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               zero;
    logic               overlap;
    logic signed [31:0] ex_full;
    logic signed [31:0] ey_full;
  } side_t;

  typedef struct packed {
    logic signed [34:0] lo;
    logic signed [34:0] hi;
    logic               big;
    logic               dneg;
    logic [31:0]        dmag;
  } axis_t;

  typedef struct packed {
    logic [NW-1:0] nq;
    logic [31:0]   rem;
    logic [31:0]   dmag;
    logic          neg;
  } lane_t;

  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // --------------------------------------------------------------------------
  // Stage 1: unpack, slab bounds, motion class, zero-motion overlap, full end
  // --------------------------------------------------------------------------
  logic signed [31:0] in_ax, in_ay, in_bx, in_by, in_dx, in_dy;
  logic [30:0]        in_ahw, in_ahh, in_bhw, in_bhh;
  axis_t              ax_c [2];
  side_t              sb_c;

  assign in_ax  = s_tdata[31:0];
  assign in_ay  = s_tdata[63:32];
  assign in_ahw = s_tdata[94:64];
  assign in_ahh = s_tdata[125:95];
  assign in_bx  = s_tdata[157:126];
  assign in_by  = s_tdata[189:158];
  assign in_bhw = s_tdata[220:190];
  assign in_bhh = s_tdata[251:221];
  assign in_dx  = s_tdata[283:252];
  assign in_dy  = s_tdata[315:284];

  function automatic axis_t axis_prep(input logic signed [31:0] ca,
                                      input logic [32:0] h,
                                      input logic signed [31:0] cb,
                                      input logic signed [31:0] d);
    axis_t r;
    logic signed [34:0] lo;
    logic signed [34:0] hi;
    logic [31:0]        m;
    lo = 35'(ca) - $signed({2'b00, h}) - 35'(cb);
    hi = 35'(ca) + $signed({2'b00, h}) - 35'(cb);
    m  = d[31] ? 32'(-d) : 32'(d);
    r.big  = m > TINY_MAX;
    r.dneg = d[31];
    r.dmag = m;
    // swap the bounds for negative motion above the threshold
    if (r.big && d[31]) begin
      r.lo = hi;
      r.hi = lo;
    end else begin
      r.lo = lo;
      r.hi = hi;
    end
    return r;
  endfunction

  function automatic logic overlaps(input logic signed [31:0] ca,
                                    input logic signed [31:0] cb,
                                    input logic [32:0] h);
    logic signed [32:0] diff;
    logic [32:0]        m;
    diff = 33'(ca) - 33'(cb);
    m    = diff[32] ? 33'(-diff) : 33'(diff);
    return h > m;
  endfunction

  always_comb begin
    logic [32:0] hw;
    logic [32:0] hh;
    hw = {2'b00, in_ahw} + {2'b00, in_bhw};
    hh = {2'b00, in_ahh} + {2'b00, in_bhh};
    ax_c[0] = axis_prep(in_ax, hw, in_bx, in_dx);
    ax_c[1] = axis_prep(in_ay, hh, in_by, in_dy);
    sb_c.bx      = in_bx;
    sb_c.by      = in_by;
    sb_c.dx      = in_dx;
    sb_c.dy      = in_dy;
    sb_c.zero    = (in_dx == 32'sd0) && (in_dy == 32'sd0);
    sb_c.overlap = overlaps(in_ax, in_bx, hw) && overlaps(in_ay, in_by, hh);
    sb_c.ex_full = sat33(33'(in_bx) + 33'(in_dx));
    sb_c.ey_full = sat33(33'(in_by) + 33'(in_dy));
  end

  logic  s1_v;
  axis_t s1_ax [2];
  side_t s1_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (advance) begin
      s1_v <= s_tvalid;
    end
    if (advance) begin
      s1_ax <= ax_c;
      s1_sb <= sb_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: form numerator and divisor of each of the four slab times
  // --------------------------------------------------------------------------
  logic signed [NSW-1:0] n_c   [4];
  logic [31:0]           dm_c  [4];
  logic                  dn_c  [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      logic signed [34:0]  val;
      logic signed [55:0]  prod;
      logic signed [NSW-1:0] shv;
      val  = l[0] ? s1_ax[l >> 1].hi : s1_ax[l >> 1].lo;
      prod = $signed({{21{val[34]}}, val}) * $signed(56'(RECIP_NUM));
      shv  = $signed({{(NSW-35){val[34]}}, val}) <<< FRAC_BITS;
      if (s1_ax[l >> 1].big) begin
        n_c[l]  = shv;
        dm_c[l] = s1_ax[l >> 1].dmag;
        dn_c[l] = s1_ax[l >> 1].dneg;
      end else begin
        n_c[l]  = NSW'(prod);
        dm_c[l] = 32'(RECIP_DEN);
        dn_c[l] = 1'b0;
      end
    end
  end

  logic                  s2_v;
  logic signed [NSW-1:0] s2_n  [4];
  logic [31:0]           s2_dm [4];
  logic                  s2_dn [4];
  side_t                 s2_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (advance) begin
      s2_v <= s1_v;
    end
    if (advance) begin
      s2_n  <= n_c;
      s2_dm <= dm_c;
      s2_dn <= dn_c;
      s2_sb <= s1_sb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 and divider: magnitudes in, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic  dv  [NW+1];
  lane_t dq  [NW+1][4];
  side_t dsb [NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (advance) begin
      dv[0] <= s2_v;
    end
    if (advance) begin
      for (int l = 0; l < 4; l++) begin
        dq[0][l].nq   <= s2_n[l][NSW-1] ? NW'(-s2_n[l]) : NW'(s2_n[l]);
        dq[0][l].rem  <= '0;
        dq[0][l].dmag <= s2_dm[l];
        dq[0][l].neg  <= s2_n[l][NSW-1] ^ s2_dn[l];
      end
      dsb[0] <= s2_sb;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    lane_t step [4];

    // shift in the next numerator bit, subtract the divisor where it fits
    always_comb begin
      for (int l = 0; l < 4; l++) begin
        logic [32:0] r;
        r = {dq[k][l].rem, dq[k][l].nq[NW-1]};
        step[l]    = dq[k][l];
        step[l].nq = {dq[k][l].nq[NW-2:0], 1'b0};
        if (r >= {1'b0, dq[k][l].dmag}) begin
          step[l].rem   = 32'(r - {1'b0, dq[k][l].dmag});
          step[l].nq[0] = 1'b1;
        end else begin
          step[l].rem = r[31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (advance) begin
        dv[k+1] <= dv[k];
      end
      if (advance) begin
        dq[k+1]  <= step;
        dsb[k+1] <= dsb[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: restore the sign of each time
  // --------------------------------------------------------------------------
  logic                  s4_v;
  logic signed [NSW-1:0] s4_t [4];
  side_t                 s4_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (advance) begin
      s4_v <= dv[NW];
    end
    if (advance) begin
      for (int l = 0; l < 4; l++) begin
        s4_t[l] <= dq[NW][l].neg ? -$signed({1'b0, dq[NW][l].nq})
                                 : $signed({1'b0, dq[NW][l].nq});
      end
      s4_sb <= dsb[NW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: slab overlap, time window, clamp entry time
  // --------------------------------------------------------------------------
  logic          hit_c;
  logic [TW-1:0] t0_c;

  always_comb begin
    logic signed [NSW-1:0] t0;
    logic signed [NSW-1:0] t1;
    logic                  disjoint;
    disjoint = (s4_t[0] > s4_t[3]) || (s4_t[2] > s4_t[1]);
    t0 = (s4_t[0] > s4_t[2]) ? s4_t[0] : s4_t[2];
    t1 = (s4_t[1] < s4_t[3]) ? s4_t[1] : s4_t[3];
    hit_c = !disjoint && !((t0 >= ONE_T) || (t1 <= 0));
    if (t0 < 0) begin
      t0_c = '0;
    end else if (t0 > ONE_T) begin
      t0_c = ONE_T[TW-1:0];
    end else begin
      t0_c = t0[TW-1:0];
    end
  end

  logic          s5_v;
  logic          s5_hit;
  logic [TW-1:0] s5_t0;
  side_t         s5_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (advance) begin
      s5_v <= s4_v;
    end
    if (advance) begin
      s5_hit <= hit_c;
      s5_t0  <= t0_c;
      s5_sb  <= s4_sb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: scale motion by entry time
  // --------------------------------------------------------------------------
  logic                 s6_v;
  logic                 s6_hit;
  logic signed [PW-1:0] s6_px;
  logic signed [PW-1:0] s6_py;
  side_t                s6_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (advance) begin
      s6_v <= s5_v;
    end
    if (advance) begin
      s6_hit <= s5_hit;
      s6_px  <= PW'(s5_sb.dx) * $signed({{(PW-TW){1'b0}}, s5_t0});
      s6_py  <= PW'(s5_sb.dy) * $signed({{(PW-TW){1'b0}}, s5_t0});
      s6_sb  <= s5_sb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: truncate toward zero, add start, saturate, pick the end point
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] stop_at(input logic signed [PW-1:0] p,
                                                 input logic signed [31:0] b);
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] q;
    adj = p + (p[PW-1] ? $signed(RND) : $signed({PW{1'b0}}));
    q   = adj >>> FRAC_BITS;
    return sat33(33'(b) + $signed(q[32:0]));
  endfunction

  logic               out_hit;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s6_v;
    end
    if (advance) begin
      if (s6_sb.zero) begin
        out_hit <= s6_sb.overlap;
        out_x   <= s6_sb.bx;
        out_y   <= s6_sb.by;
      end else if (s6_hit) begin
        out_hit <= 1'b1;
        out_x   <= stop_at(s6_px, s6_sb.bx);
        out_y   <= stop_at(s6_py, s6_sb.by);
      end else begin
        out_hit <= 1'b0;
        out_x   <= s6_sb.ex_full;
        out_y   <= s6_sb.ey_full;
      end
    end
  end

  assign m_tdata = {7'd0, out_y, out_x, out_hit};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_holds_div : assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(dv[0]) && $stable(dv[NW]))
    else $error("divider moved during a stall");

  a_entry_clamped : assert property (@(posedge clk) disable iff (rst)
    s5_v |-> (s5_t0 <= ONE_T[TW-1:0]))
    else $error("entry time outside the unit window");

  a_zero_motion_no_scale : assert property (@(posedge clk) disable iff (rst)
    (advance && s6_v && s6_sb.zero) |=> (out_x == $past(s6_sb.bx)))
    else $error("zero motion moved the box");

endmodule
